### rtl/vrp_pkg.sv
// Shared types, codes and constants of the vertex rotate/project block.
// Holds the CORDIC arctangent table and coordinate saturation.
// No dependencies.
package vrp_pkg;

  // Coordinate format: Q16.16 in 32 bits, three per stored vertex
  localparam int COORD_W  = 32;
  localparam int VTX_W    = 3 * COORD_W;
  localparam int SAT_IN_W = 50;

  // Function codes of an input beat
  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_ROTATE  = 2'd1;
  localparam logic [1:0] FUNC_TRANS   = 2'd2;
  localparam logic [1:0] FUNC_PROJECT = 2'd3;

  // Rotation planes
  localparam logic [1:0] PLANE_XZ   = 2'd0;
  localparam logic [1:0] PLANE_YZ   = 2'd1;
  localparam logic [1:0] PLANE_XY   = 2'd2;
  localparam logic [1:0] PLANE_NONE = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_FOV    = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  // Configuration reset values
  localparam logic signed [15:0] FOV_RESET    = 16'sd5;
  localparam logic [14:0]        WIDTH_RESET  = 15'd640;
  localparam logic [14:0]        HEIGHT_RESET = 15'd480;

  // Angles in 1/128 degree: full, half and quarter turn (360, 180, 90 degrees)
  localparam int TURN_UNITS    = 46080;
  localparam int HALF_TURN     = 23040;
  localparam int QUARTER_TURN  = 11520;
  localparam int CORDIC_STEPS  = 16;
  localparam int CORDIC_X0     = 19898;

  // Sine/cosine pair from the CORDIC unit
  typedef struct packed {
    logic               done;
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
  } cs_res_t;

  // Quotient from the divide unit
  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [15:0] quot;
  } div_res_t;

  // atan(2^-k) in 1/32768 degree
  function automatic logic [20:0] atan_entry(input logic [3:0] k);
    logic [20:0] r;
    case (k)
      4'd0:    r = 21'd1474560;
      4'd1:    r = 21'd870484;
      4'd2:    r = 21'd459940;
      4'd3:    r = 21'd233473;
      4'd4:    r = 21'd117189;
      4'd5:    r = 21'd58652;
      4'd6:    r = 21'd29333;
      4'd7:    r = 21'd14667;
      4'd8:    r = 21'd7334;
      4'd9:    r = 21'd3667;
      4'd10:   r = 21'd1834;
      4'd11:   r = 21'd917;
      4'd12:   r = 21'd458;
      4'd13:   r = 21'd229;
      4'd14:   r = 21'd115;
      default: r = 21'd57;
    endcase
    return r;
  endfunction

  // Saturate a wide signed value to the coordinate width
  function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [SAT_IN_W-1:0] v);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = SAT_IN_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - SAT_IN_W'(1);
    if (v > hi) return {1'b0, {(COORD_W-1){1'b1}}};
    if (v < lo) return {1'b1, {(COORD_W-1){1'b0}}};
    return v[COORD_W-1:0];
  endfunction

endpackage

### rtl/vrp_cordic.sv
// Iterative CORDIC: cosine and sine in Q1.15 of an angle in 1/128 degree.
// One micro-rotation per cycle, 16 in all. Depends on vrp_pkg.
module vrp_cordic import vrp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [16:0] angle_i,
  output cs_res_t            res_o
);

  logic signed [18:0] a0, a1, a2, a3, a4, a5;
  logic               fold;
  logic signed [18:0] x_q, y_q, x_n, y_n, xsh, ysh;
  logic signed [25:0] z_q, z_n;
  logic [3:0]         k_q;
  logic               busy_q, done_q, neg_q;
  logic signed [15:0] cos_q, sin_q;
  logic               dir;

  function automatic logic signed [15:0] clamp15(input logic signed [18:0] v);
    if (v > 19'sd32767) return 16'sd32767;
    if (v < -19'sd32767) return -16'sd32767;
    return v[15:0];
  endfunction

  // Reduce into one turn, then fold into [-90, 90] degrees
  always_comb begin
    a0 = 19'(angle_i);
    a1 = (a0 < 0) ? a0 + 19'(TURN_UNITS) : a0;
    a2 = (a1 < 0) ? a1 + 19'(TURN_UNITS) : a1;
    a3 = (a2 >= 19'(TURN_UNITS)) ? a2 - 19'(TURN_UNITS) : a2;
    a4 = (a3 >= 19'(HALF_TURN)) ? a3 - 19'(TURN_UNITS) : a3;
    fold = 1'b0;
    a5 = a4;
    if (a4 > 19'(QUARTER_TURN)) begin
      a5 = a4 - 19'(HALF_TURN);
      fold = 1'b1;
    end else if (a4 < -19'(QUARTER_TURN)) begin
      a5 = a4 + 19'(HALF_TURN);
      fold = 1'b1;
    end
  end

  // One micro-rotation
  always_comb begin
    xsh = x_q >>> k_q;
    ysh = y_q >>> k_q;
    dir = ~z_q[25];
    x_n = dir ? x_q - ysh : x_q + ysh;
    y_n = dir ? y_q + xsh : y_q - xsh;
    z_n = dir ? z_q - 26'(atan_entry(k_q)) : z_q + 26'(atan_entry(k_q));
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        k_q    <= '0;
      end else if (busy_q) begin
        k_q <= k_q + 4'd1;
        if (k_q == 4'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= 19'(CORDIC_X0);
      y_q   <= '0;
      z_q   <= 26'(a5) <<< 8;
      neg_q <= fold;
    end else if (busy_q) begin
      x_q <= x_n;
      y_q <= y_n;
      z_q <= z_n;
      if (k_q == 4'(CORDIC_STEPS - 1)) begin
        cos_q <= clamp15(neg_q ? -x_n : x_n);
        sin_q <= clamp15(neg_q ? -y_n : y_n);
      end
    end
  end

  assign res_o.done  = done_q;
  assign res_o.cos_v = cos_q;
  assign res_o.sin_v = sin_q;

endmodule

### rtl/vrp_divider.sv
// Restoring divider for the projection: 16 quotient bits, one per cycle,
// with an up-front overflow check when the quotient needs 17 bits or more.
// Depends on vrp_pkg.
module vrp_divider import vrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [62:0] dividend_i,
  input  logic [33:0] divisor_i,
  output div_res_t    res_o
);

  logic        busy_q, done_q, ovf_q;
  logic [3:0]  cnt_q;
  logic [33:0] rem_q, b_q;
  logic [15:0] ql_q;
  logic [34:0] r2;
  logic        ge, ovf;

  // Quotient would need 17+ bits
  assign ovf = dividend_i >= {13'd0, divisor_i, 16'd0};

  always_comb begin
    r2 = {rem_q, ql_q[15]};
    ge = r2 >= {1'b0, b_q};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (ovf) done_q <= 1'b1;
        else     busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend low bits shift out as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ovf_q <= ovf;
      b_q   <= divisor_i;
      rem_q <= dividend_i[49:16];
      ql_q  <= dividend_i[15:0];
    end else if (busy_q) begin
      rem_q <= ge ? 34'(r2 - {1'b0, b_q}) : r2[33:0];
      ql_q  <= {ql_q[14:0], ge};
    end
  end

  assign res_o.done = done_q;
  assign res_o.ovf  = ovf_q;
  assign res_o.quot = ql_q;

endmodule

### rtl/vertex_rotate_project_core.sv
// Vertex store with rotate, translate and perspective projection.
// Top level: vertex memory, sequencer, shared multiplier, output register.
// Depends on vrp_pkg, vrp_cordic, vrp_divider.
//
// Usage: input beats carry a function code. A load writes one vertex and
// sets the count to its index plus one; rotate, translate and project walk
// vertices 0 .. count-1 through a single-port-read memory (read, modify and,
// bar project, write back one at a time, so no two accesses ever overlap).
// Only project returns beats: one per vertex in index order, the last one
// flagged by last_vertex_o. in_ready_o is high only between items.
// Per item: a load is a single write; translate reads and writes back each
// vertex; rotate first runs the CORDIC (one step a cycle), then for each
// vertex forms four products through one shared 32x16 multiplier; project
// runs the divider once for each screen axis of each vertex (skipped, giving
// zero, when the depth term is not negative). Plane 3 rotates, and translate
// or project on an empty store, go straight back to idle.
// The result sits in an output register; while the receiver stalls the
// sequencer computes the next vertex and holds it until the register frees.
// Reset clears the vertex count and loads the configuration defaults; the
// memory itself is not cleared. Configuration writes take effect at once;
// the user must make them between items, which the block does not enforce.
module vertex_rotate_project_core import vrp_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic [5:0]         vertex_index_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic signed [31:0] view_distance_i,
  input  logic [1:0]         rotation_plane_i,
  input  logic signed [16:0] angle_degrees_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         out_index_o,
  output logic signed [15:0] screen_x_o,
  output logic signed [15:0] screen_y_o,
  output logic               last_vertex_o
);

  localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CORD = 5'd1;
  localparam logic [4:0] S_RD   = 5'd2;
  localparam logic [4:0] S_ROT0 = 5'd3;
  localparam logic [4:0] S_ROT1 = 5'd4;
  localparam logic [4:0] S_ROT2 = 5'd5;
  localparam logic [4:0] S_ROT3 = 5'd6;
  localparam logic [4:0] S_ROT4 = 5'd7;
  localparam logic [4:0] S_ROTW = 5'd8;
  localparam logic [4:0] S_TRW  = 5'd9;
  localparam logic [4:0] S_PA   = 5'd10;
  localparam logic [4:0] S_PM   = 5'd11;
  localparam logic [4:0] S_PN   = 5'd12;
  localparam logic [4:0] S_PL   = 5'd13;
  localparam logic [4:0] S_PH   = 5'd14;
  localparam logic [4:0] S_PS   = 5'd15;
  localparam logic [4:0] S_PD   = 5'd16;
  localparam logic [4:0] S_PW   = 5'd17;
  localparam logic [4:0] S_OUT  = 5'd18;

  logic [4:0]          state_q, state_d;
  logic [CNT_W-1:0]    count_q;
  logic [AW-1:0]       idx_q;
  logic [1:0]          func_q, plane_q;
  logic signed [31:0]  ox_q, oy_q, oz_q, dist_q;
  logic signed [15:0]  fov_q;
  logic [14:0]         width_q, height_q;

  logic [VTX_W-1:0]    vtx_mem [MAX_VERTICES];
  logic [VTX_W-1:0]    rd_q, wr_data;
  logic [AW-1:0]       wr_addr;
  logic                rd_en, wr_en;

  logic signed [31:0]  vx, vy, vz, u, v, nu, nv;
  logic signed [31:0]  mul_a;
  logic signed [15:0]  mul_b;
  logic signed [47:0]  prod_q;
  logic signed [48:0]  acc_u_q, acc_v_q;
  logic                plane0;

  logic signed [31:0]  xs_q, ys_q, zs;
  logic signed [32:0]  d_q;
  logic signed [48:0]  n_val;
  logic [47:0]         a_q;
  logic                pos_q, axis_q;
  logic [62:0]         nacc_q;
  logic [33:0]         negd, div_b;
  logic [14:0]         size;
  logic signed [15:0]  res_x_q, res_y_q, pv;

  logic                in_fire, load_ok, last_v, out_load, idx_clr, idx_inc;
  logic                cord_start, div_start;
  cs_res_t             cs_res;
  div_res_t            div_res;

  logic                out_valid_q, last_q;
  logic [5:0]          out_index_q;
  logic signed [15:0]  screen_x_q, screen_y_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign load_ok    = 32'(vertex_index_i) < 32'(MAX_VERTICES);
  assign last_v     = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;

  // Vertex fields of the word read back
  assign vx = rd_q[COORD_W-1:0];
  assign vy = rd_q[2*COORD_W-1:COORD_W];
  assign vz = rd_q[3*COORD_W-1:2*COORD_W];

  // Rotation operands: u, v are the two coordinates of the plane
  assign plane0 = (plane_q == PLANE_XZ);
  assign u      = (plane_q == PLANE_YZ) ? vy : vx;
  assign v      = (plane_q == PLANE_XY) ? vy : vz;
  assign nu     = sat_coord(SAT_IN_W'(acc_u_q >>> 15));
  assign nv     = sat_coord(SAT_IN_W'(acc_v_q >>> 15));

  // Projection helpers
  assign zs    = sat_coord(SAT_IN_W'(vz) + SAT_IN_W'(oz_q) - SAT_IN_W'(dist_q));
  assign n_val = 49'(d_q) - 49'(prod_q);
  assign negd  = 34'(0) - 34'(d_q);
  assign div_b = {negd[32:0], 1'b0};
  assign size  = axis_q ? height_q : width_q;

  // Saturated screen value from the quotient
  always_comb begin
    if (div_res.ovf) begin
      pv = pos_q ? 16'sh7fff : 16'sh8000;
    end else if (pos_q) begin
      pv = (div_res.quot > 16'd32767) ? 16'sh7fff : div_res.quot;
    end else begin
      pv = (div_res.quot > 16'd32768) ? 16'sh8000 : 16'(17'd0 - {1'b0, div_res.quot});
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_ROT0: begin mul_a = u; mul_b = cs_res.cos_v; end
      S_ROT1: begin mul_a = v; mul_b = cs_res.sin_v; end
      S_ROT2: begin mul_a = v; mul_b = cs_res.cos_v; end
      S_ROT3: begin mul_a = u; mul_b = cs_res.sin_v; end
      S_PM:   begin mul_a = axis_q ? ys_q : xs_q; mul_b = fov_q; end
      S_PL:   begin mul_a = {8'd0, a_q[23:0]}; mul_b = {1'b0, size}; end
      S_PH:   begin mul_a = {8'd0, a_q[47:24]}; mul_b = {1'b0, size}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = idx_q;
    wr_data    = rd_q;
    cord_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    idx_clr    = 1'b0;
    idx_inc    = 1'b0;
    case (state_q)
      S_IDLE: begin
        idx_clr = 1'b1;
        if (in_fire) begin
          case (func_i)
            FUNC_LOAD: begin
              if (load_ok) begin
                wr_en   = 1'b1;
                wr_addr = AW'(vertex_index_i);
                wr_data = {coord_z_i, coord_y_i, coord_x_i};
              end
            end
            FUNC_ROTATE: begin
              if (rotation_plane_i != PLANE_NONE) begin
                cord_start = 1'b1;
                state_d    = S_CORD;
              end
            end
            default: begin
              if (count_q != '0) state_d = S_RD;
            end
          endcase
        end
      end
      S_CORD: begin
        if (cs_res.done) state_d = (count_q != '0) ? S_RD : S_IDLE;
      end
      S_RD: begin
        rd_en = 1'b1;
        case (func_q)
          FUNC_ROTATE: state_d = S_ROT0;
          FUNC_TRANS:  state_d = S_TRW;
          default:     state_d = S_PA;
        endcase
      end
      S_ROT0: state_d = S_ROT1;
      S_ROT1: state_d = S_ROT2;
      S_ROT2: state_d = S_ROT3;
      S_ROT3: state_d = S_ROT4;
      S_ROT4: state_d = S_ROTW;
      S_ROTW: begin
        wr_en = 1'b1;
        case (plane_q)
          PLANE_YZ: wr_data = {nv, nu, vx};
          PLANE_XY: wr_data = {vz, nv, nu};
          default:  wr_data = {nv, vy, nu};
        endcase
        idx_inc = ~last_v;
        state_d = last_v ? S_IDLE : S_RD;
      end
      S_TRW: begin
        wr_en   = 1'b1;
        wr_data = {sat_coord(SAT_IN_W'(vz) + SAT_IN_W'(oz_q)),
                   sat_coord(SAT_IN_W'(vy) + SAT_IN_W'(oy_q)),
                   sat_coord(SAT_IN_W'(vx) + SAT_IN_W'(ox_q))};
        idx_inc = ~last_v;
        state_d = last_v ? S_IDLE : S_RD;
      end
      S_PA: state_d = S_PM;
      S_PM: state_d = d_q[32] ? S_PN : S_OUT;
      S_PN: state_d = S_PL;
      S_PL: state_d = S_PH;
      S_PH: state_d = S_PS;
      S_PS: state_d = S_PD;
      S_PD: begin
        div_start = 1'b1;
        state_d   = S_PW;
      end
      S_PW: begin
        if (div_res.done) state_d = axis_q ? S_OUT : S_PM;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          idx_inc  = ~last_v;
          state_d  = last_v ? S_IDLE : S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Vertex memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) vtx_mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= vtx_mem[idx_q];
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      fov_q       <= FOV_RESET;
      width_q     <= WIDTH_RESET;
      height_q    <= HEIGHT_RESET;
    end else begin
      state_q <= state_d;
      if (idx_clr)      idx_q <= '0;
      else if (idx_inc) idx_q <= idx_q + AW'(1);
      if (in_fire && func_i == FUNC_LOAD && load_ok)
        count_q <= CNT_W'(32'(vertex_index_i) + 32'd1);
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FOV:    fov_q    <= cfg_wdata_i;
          CFG_WIDTH:  width_q  <= cfg_wdata_i[14:0];
          CFG_HEIGHT: height_q <= cfg_wdata_i[14:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_fire) begin
      func_q  <= func_i;
      plane_q <= rotation_plane_i;
      ox_q    <= coord_x_i;
      oy_q    <= coord_y_i;
      oz_q    <= coord_z_i;
      dist_q  <= view_distance_i;
    end
    case (state_q)
      S_ROT1: acc_u_q <= 49'(prod_q);
      S_ROT2: acc_u_q <= plane0 ? acc_u_q + 49'(prod_q) : acc_u_q - 49'(prod_q);
      S_ROT3: acc_v_q <= 49'(prod_q);
      S_ROT4: acc_v_q <= plane0 ? acc_v_q - 49'(prod_q) : acc_v_q + 49'(prod_q);
      S_PA: begin
        xs_q   <= sat_coord(SAT_IN_W'(vx) + SAT_IN_W'(ox_q));
        ys_q   <= sat_coord(SAT_IN_W'(vy) + SAT_IN_W'(oy_q));
        d_q    <= 33'($signed({fov_q, 16'd0})) + 33'(zs);
        axis_q <= 1'b0;
      end
      S_PM: begin
        if (!d_q[32]) begin
          res_x_q <= '0;
          res_y_q <= '0;
        end
      end
      S_PN: begin
        a_q   <= n_val[48] ? 48'(-n_val) : 48'(n_val);
        pos_q <= n_val[48];
      end
      S_PH: nacc_q <= 63'(prod_q[38:0]);
      S_PS: nacc_q <= nacc_q + {prod_q[38:0], 24'd0};
      S_PW: begin
        if (div_res.done) begin
          if (axis_q) res_y_q <= pv;
          else        res_x_q <= pv;
          axis_q <= 1'b1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_index_q <= 6'(idx_q);
      screen_x_q  <= res_x_q;
      screen_y_q  <= res_y_q;
      last_q      <= last_v;
    end
  end

  vrp_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .angle_i (angle_degrees_i),
    .res_o   (cs_res)
  );

  vrp_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (nacc_q),
    .divisor_i  (div_b),
    .res_o      (div_res)
  );

  assign out_valid_o   = out_valid_q;
  assign out_index_o   = out_index_q;
  assign screen_x_o    = screen_x_q;
  assign screen_y_o    = screen_y_q;
  assign last_vertex_o = last_q;

endmodule

### verif/tb_vertex_rotate_project_core.sv
// Self-checking testbench for vertex_rotate_project_core: directed and random
// load/rotate/translate/project beats, with an in-bench model of the vertex store.
// Depends on vrp_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_vertex_rotate_project_core;
  import vrp_pkg::*;

  localparam int NVTX      = 64;
  localparam int HOLD_OFF  = 4000;
  localparam int MAX_CYC   = 10000000;

  typedef struct {
    logic [1:0]         func;
    logic [5:0]         vidx;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [31:0] vdist;
    logic [1:0]         plane;
    logic signed [16:0] ang;
  } vtx_cmd_t;

  typedef struct {
    logic [5:0]         idx;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic               last;
  } pix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = CFG_FOV;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  vtx_cmd_t cur = '{default: '0};
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] out_index;
  logic signed [15:0] screen_x;
  logic signed [15:0] screen_y;
  logic last_vertex;

  vtx_cmd_t   cmd_q[$];
  pix_t       pix_q[$];
  int         errors = 0;
  int         cycles = 0;
  bit         no_idle = 1'b0;
  int         filled = 0;

  // shadow of the block's state and registers
  longint     mdl_vtx[NVTX][3];
  int         mdl_count = 0;
  longint     mdl_fov = 5;
  longint     mdl_w = 640;
  longint     mdl_h = 480;

  vertex_rotate_project_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .func_i(cur.func), .vertex_index_i(cur.vidx),
    .coord_x_i(cur.cx), .coord_y_i(cur.cy), .coord_z_i(cur.cz),
    .view_distance_i(cur.vdist), .rotation_plane_i(cur.plane),
    .angle_degrees_i(cur.ang),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_index_o(out_index), .screen_x_o(screen_x), .screen_y_o(screen_y),
    .last_vertex_o(last_vertex)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_q15(longint v);
    if (v > 32767) return 32767;
    if (v < -32767) return -32767;
    return v;
  endfunction

  // CORDIC sine/cosine in Q1.15 after folding into [-90,90] degrees
  task automatic cordic_cs(input longint ang, output longint c, output longint s);
    longint a, x, y, z, t;
    bit neg;
    a = ang % TURN_UNITS;
    x = CORDIC_X0;
    y = 0;
    neg = 1'b0;
    if (a < 0) a += TURN_UNITS;
    if (a >= HALF_TURN) a -= TURN_UNITS;
    if (a > QUARTER_TURN) begin
      a -= HALF_TURN; neg = 1'b1;
    end else if (a < -QUARTER_TURN) begin
      a += HALF_TURN; neg = 1'b1;
    end
    z = a * 256;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= longint'(atan_entry(4'(i)));
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += longint'(atan_entry(4'(i)));
      end
    end
    if (neg) begin
      x = -x; y = -y;
    end
    c = clamp_q15(x);
    s = clamp_q15(y);
  endtask

  // exact perspective divide, truncated and saturated to 16 bits
  function automatic longint screen_coord(longint d, longint cq, longint fov, longint size);
    longint n;
    longint unsigned a, b, q, r, mag;
    n = d - cq * fov;
    a = (n < 0) ? longint'(-n) : n;
    b = 2 * longint'(-d);
    q = a / b;
    r = a % b;
    if (size == 0 || n == 0) return 0;
    if (q > 65536) mag = 65536;
    else mag = q * size + (r * size) / b;
    if (n > 0) return (mag > 32768) ? -32768 : -longint'(mag);
    return (mag > 32767) ? 32767 : longint'(mag);
  endfunction

  // append a beat to the pending list
  task automatic queue_cmd(input vtx_cmd_t it);
    cmd_q = {cmd_q, it};
  endtask

  // update the shadow store for one accepted beat, queue any pixels
  task automatic apply_cmd(input vtx_cmd_t it);
    longint c, s, u, v, nu, nv, xs, ys, zs, d;
    int p, q;
    pix_t px;
    case (it.func)
      FUNC_LOAD: begin
        mdl_vtx[it.vidx][0] = it.cx;
        mdl_vtx[it.vidx][1] = it.cy;
        mdl_vtx[it.vidx][2] = it.cz;
        mdl_count = int'(it.vidx) + 1;
      end
      FUNC_ROTATE: begin
        if (it.plane != PLANE_NONE) begin
          cordic_cs(it.ang, c, s);
          p = (it.plane == PLANE_YZ) ? 1 : 0;
          q = (it.plane == PLANE_XY) ? 1 : 2;
          for (int i = 0; i < mdl_count; i++) begin
            u = mdl_vtx[i][p];
            v = mdl_vtx[i][q];
            if (it.plane == PLANE_XZ) begin
              nu = u * c + v * s; nv = v * c - u * s;
            end else begin
              nu = u * c - v * s; nv = u * s + v * c;
            end
            mdl_vtx[i][p] = sat32(nu >>> 15);
            mdl_vtx[i][q] = sat32(nv >>> 15);
          end
        end
      end
      FUNC_TRANS: begin
        for (int i = 0; i < mdl_count; i++) begin
          mdl_vtx[i][0] = sat32(mdl_vtx[i][0] + it.cx);
          mdl_vtx[i][1] = sat32(mdl_vtx[i][1] + it.cy);
          mdl_vtx[i][2] = sat32(mdl_vtx[i][2] + it.cz);
        end
      end
      default: begin
        for (int i = 0; i < mdl_count; i++) begin
          xs = sat32(mdl_vtx[i][0] + it.cx);
          ys = sat32(mdl_vtx[i][1] + it.cy);
          zs = sat32(mdl_vtx[i][2] + it.cz - it.vdist);
          d = mdl_fov * 65536 + zs;
          px.idx = i[5:0];
          px.px = '0;
          px.py = '0;
          if (d < 0) begin
            px.px = 16'(screen_coord(d, xs, mdl_fov, mdl_w));
            px.py = 16'(screen_coord(d, ys, mdl_fov, mdl_h));
          end
          px.last = (i + 1 == mdl_count);
          pix_q = {pix_q, px};
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return 32'(int'($urandom_range(2097152)) - 1048576);
    endcase
  endfunction

  // random beat; loads never leave an unwritten slot below the count
  function automatic vtx_cmd_t rand_cmd();
    vtx_cmd_t it;
    int pick, top;
    it.cx = rand_coord();
    it.cy = rand_coord();
    it.cz = rand_coord();
    it.vdist = ($urandom_range(1)) ? $urandom : 32'($urandom_range(8000000));
    it.plane = 2'($urandom_range(3));
    it.ang = 17'(int'($urandom_range(92160)) - 46080);
    it.vidx = 6'($urandom);
    pick = $urandom_range(99);
    if (pick < 40 || filled == 0) begin
      it.func = FUNC_LOAD;
      top = (filled > 63) ? 63 : filled;
      if ($urandom_range(5) == 0) it.vidx = 6'(top);
      else it.vidx = 6'($urandom_range((top > 12) ? 12 : top));
      if (int'(it.vidx) == filled) filled++;
    end else if (pick < 60) it.func = FUNC_ROTATE;
    else if (pick < 75) it.func = FUNC_TRANS;
    else it.func = FUNC_PROJECT;
    return it;
  endfunction

  function automatic vtx_cmd_t mk_cmd(logic [1:0] f, logic [5:0] vi, logic signed [31:0] x,
                                      logic signed [31:0] y, logic signed [31:0] z,
                                      logic signed [31:0] dd, logic [1:0] pl,
                                      logic signed [16:0] an);
    vtx_cmd_t it;
    it.func = f; it.vidx = vi; it.cx = x; it.cy = y; it.cz = z;
    it.vdist = dd; it.plane = pl; it.ang = an;
    return it;
  endfunction

  // input driver: one beat in flight, random gaps
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_cmd(cur);
      if (!in_valid || in_ready) begin
        if (cmd_q.size() > 0 && (no_idle || $urandom_range(99) >= 32)) begin
          cur <= cmd_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and receiver stalls
  always @(posedge clk or negedge rst_n) begin
    pix_t w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      cycles <= cycles + 1;
      if (cycles >= MAX_CYC) begin
        $display("FAIL");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pix_q.size() == 0) begin
          report_mismatch("unexpected beat, index", out_index, -1);
        end else begin
          w = pix_q.pop_front();
          if (out_index !== w.idx) report_mismatch("out_index", out_index, w.idx);
          if (screen_x !== w.px) report_mismatch("screen_x", screen_x, w.px);
          if (screen_y !== w.py) report_mismatch("screen_y", screen_y, w.py);
          if (last_vertex !== w.last) report_mismatch("last_vertex", last_vertex, w.last);
        end
      end
      out_ready <= no_idle || ($urandom_range(99) >= 32);
    end
  end

  task automatic wait_drained();
    while (cmd_q.size() > 0 || in_valid || pix_q.size() > 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FOV:   mdl_fov = longint'($signed(val));
      CFG_WIDTH: mdl_w = val[14:0];
      default:   mdl_h = val[14:0];
    endcase
  endtask

  task automatic set_regs(input logic [15:0] f, input logic [15:0] w, input logic [15:0] h);
    write_reg(CFG_FOV, f);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  task automatic random_phase(input int n);
    repeat (n) queue_cmd(rand_cmd());
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, extremes, every plane and operation
    queue_cmd(mk_cmd(FUNC_PROJECT, 0, 0, 0, 0, 0, PLANE_XZ, 0));
    queue_cmd(mk_cmd(FUNC_LOAD, 0, 32'sh7fffffff, 32'sh80000000, -32'sd1000000,
                     0, 0, 0));
    queue_cmd(mk_cmd(FUNC_LOAD, 1, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                     0, 0, 0));
    queue_cmd(mk_cmd(FUNC_LOAD, 2, 32'sd65536, -32'sd131072, -32'sd655360, 0, 0, 0));
    queue_cmd(mk_cmd(FUNC_PROJECT, 0, 0, 0, 0, 32'sd1000000, 0, 0));
    queue_cmd(mk_cmd(FUNC_ROTATE, 0, 0, 0, 0, 0, PLANE_XZ, 17'sd11520));
    queue_cmd(mk_cmd(FUNC_ROTATE, 0, 0, 0, 0, 0, PLANE_YZ, -17'sd46080));
    queue_cmd(mk_cmd(FUNC_ROTATE, 0, 0, 0, 0, 0, PLANE_XY, 17'sd46080));
    queue_cmd(mk_cmd(FUNC_ROTATE, 0, 0, 0, 0, 0, PLANE_NONE, 17'sd5000));
    queue_cmd(mk_cmd(FUNC_ROTATE, 0, 0, 0, 0, 0, PLANE_XY, 17'sd23040));
    queue_cmd(mk_cmd(FUNC_ROTATE, 0, 0, 0, 0, 0, PLANE_XZ, -17'sd23040));
    queue_cmd(mk_cmd(FUNC_PROJECT, 0, 0, 0, 0, -32'sd1000000, 0, 0));
    queue_cmd(mk_cmd(FUNC_TRANS, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                     0, 0, 0));
    queue_cmd(mk_cmd(FUNC_TRANS, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                     0, 0, 0));
    queue_cmd(mk_cmd(FUNC_PROJECT, 0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                     32'sh7fffffff, 0, 0));
    queue_cmd(mk_cmd(FUNC_LOAD, 0, 32'sd10, 32'sd20, -32'sd2000000, 0, 0, 0));
    queue_cmd(mk_cmd(FUNC_PROJECT, 0, 0, 0, 0, 0, 0, 0));
    filled = 3;
    wait_drained();

    random_phase(70);

    // fill every slot, then project all of them, no stalls
    no_idle = 1'b1;
    set_regs(-16'sd32768, 16'd32767, 16'd0);
    for (int i = filled; i < NVTX; i++)
      queue_cmd(mk_cmd(FUNC_LOAD, 6'(i), rand_coord(), rand_coord(), rand_coord(),
                       0, 0, 0));
    filled = NVTX;
    queue_cmd(mk_cmd(FUNC_PROJECT, 0, 0, 0, 0, $urandom, 0, 0));
    random_phase(40);
    no_idle = 1'b0;

    set_regs(16'sd32767, 16'd0, 16'd32767);
    random_phase(50);
    set_regs(-16'sd3, 16'd640, 16'd480);
    random_phase(60);
    set_regs(16'($urandom), 16'($urandom), 16'($urandom));
    random_phase(50);
    set_regs(16'sd5, 16'd640, 16'd480);
    random_phase(40);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
